### rtl/core/eig_pkg.sv
// ============================================================================
// eig_pkg : shared constants for the 2x2 eigenvalue pipeline
// Entry width default and the fixed result width with its saturation limits.
// ============================================================================
`default_nettype none

package eig_pkg;

   // default width of one matrix entry, signed Q8.8
   localparam int ENTRY_WIDTH_DEF = 16;

   // result width, units of 1/512
   localparam int OUT_WIDTH = 19;
   localparam int OUT_MAX   = 2 ** (OUT_WIDTH - 1) - 1;
   localparam int OUT_MIN   = -(2 ** (OUT_WIDTH - 1));

endpackage : eig_pkg

`default_nettype wire

### rtl/core/eigenvalues_2x2.sv
// ============================================================================
// eigenvalues_2x2 : eigenvalues of a signed Q8.8 2x2 matrix
// Real pair as trace +- floored root, complex pair as trace and root, all in
// units of 1/512, with a real flag.
// ============================================================================
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   four matrix entries, ENTRY_WIDTH each
//  rsp      out        rsp_valid/rsp_ready   first, second (19 bits), is_real
//
//  One beat per cycle sustained while rsp_ready stays high. The pipeline holds
//  three front stages, one square-root stage per root bit and one result
//  stage; the root pipeline sets the depth.
//  Synchronous active-high reset empties the pipeline; no clearing pass.
//  A stalled consumer freezes only the full stages: bubbles keep closing,
//  so req_ready stays high until every stage holds a beat.
// ============================================================================
`default_nettype none

module eigenvalues_2x2 import eig_pkg::*; #(
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_top_left,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_top_right,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_bottom_left,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_bottom_right,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [OUT_WIDTH-1:0]   rsp_first_value,
   output logic signed [OUT_WIDTH-1:0]   rsp_second_value,
   output logic                          rsp_is_real
);

   localparam int W = ENTRY_WIDTH;

   logic                 fr_valid;
   logic                 fr_ready;
   logic signed [W:0]    fr_trace;
   logic [2*W+1:0]       fr_mag;
   logic                 fr_real;

   logic                 ro_valid;
   logic                 ro_ready;
   logic signed [W:0]    ro_trace;
   logic [W:0]           ro_root;
   logic                 ro_real;

   // trace and discriminant
   eig_front #(
      .ENTRY_WIDTH(ENTRY_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_a     (req_entry_top_left),
      .in_b     (req_entry_top_right),
      .in_c     (req_entry_bottom_left),
      .in_d     (req_entry_bottom_right),
      .out_valid(fr_valid),
      .out_ready(fr_ready),
      .out_trace(fr_trace),
      .out_mag  (fr_mag),
      .out_real (fr_real)
   );

   // square root of the discriminant magnitude
   eig_root #(
      .ENTRY_WIDTH(ENTRY_WIDTH)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fr_valid),
      .in_ready (fr_ready),
      .in_trace (fr_trace),
      .in_mag   (fr_mag),
      .in_real  (fr_real),
      .out_valid(ro_valid),
      .out_ready(ro_ready),
      .out_trace(ro_trace),
      .out_root (ro_root),
      .out_real (ro_real)
   );

   // final sums and output register
   eig_out #(
      .ENTRY_WIDTH(ENTRY_WIDTH)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ro_valid),
      .in_ready  (ro_ready),
      .in_trace  (ro_trace),
      .in_root   (ro_root),
      .in_real   (ro_real),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_first (rsp_first_value),
      .out_second(rsp_second_value),
      .out_real  (rsp_is_real)
   );

endmodule : eigenvalues_2x2

`default_nettype wire

### rtl/core/eig_front.sv
// ============================================================================
// eig_front : trace and discriminant stages
// Three register stages: trace and |a-d|, the two products, then the signed
// discriminant with its magnitude and the real flag.
// ============================================================================
`default_nettype none

module eig_front import eig_pkg::*; #(
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [ENTRY_WIDTH-1:0] in_a,
   input  logic signed [ENTRY_WIDTH-1:0] in_b,
   input  logic signed [ENTRY_WIDTH-1:0] in_c,
   input  logic signed [ENTRY_WIDTH-1:0] in_d,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [ENTRY_WIDTH:0]   out_trace,
   output logic [2*ENTRY_WIDTH+1:0]      out_mag,
   output logic                          out_real
);

   localparam int W  = ENTRY_WIDTH;
   localparam int DW = 2 * W + 2;
   localparam int SW = 2 * W + 3;

   logic [2:0] v_ff;
   logic [2:0] en;

   // stage 1 registers
   logic signed [W:0]     tr1_ff;
   logic [W-1:0]          pm1_ff;
   logic signed [W-1:0]   b1_ff;
   logic signed [W-1:0]   c1_ff;
   // stage 2 registers
   logic signed [W:0]     tr2_ff;
   logic [2*W-1:0]        psq2_ff;
   logic signed [2*W-1:0] q2_ff;
   // stage 3 registers
   logic signed [W:0]     tr3_ff;
   logic [DW-1:0]         mag3_ff;
   logic                  real3_ff;

   logic signed [W:0]     tr1_in;
   logic signed [W:0]     diff;
   logic [W-1:0]          pm1_in;
   logic [2*W-1:0]        psq2_in;
   logic signed [2*W-1:0] q2_in;
   logic signed [SW-1:0]  disc;
   logic signed [SW-1:0]  disc_neg;
   logic                  real3_in;
   logic [DW-1:0]         mag3_in;

   // a stage advances when it is empty or some later stage can move
   assign en[2]    = out_ready || !v_ff[2];
   assign en[1]    = out_ready || !(&v_ff[2:1]);
   assign en[0]    = out_ready || !(&v_ff[2:0]);
   assign in_ready = en[0];

   // stage 1: trace and absolute difference of the diagonal
   always_comb begin
      tr1_in = (W + 1)'(in_a) + (W + 1)'(in_d);
      diff   = (W + 1)'(in_a) - (W + 1)'(in_d);
      pm1_in = diff[W] ? W'(-diff) : W'(diff);
   end

   // stage 2: square of the difference and the off-diagonal product
   always_comb begin
      psq2_in = (2 * W)'(pm1_ff) * (2 * W)'(pm1_ff);
      q2_in   = (2 * W)'(b1_ff) * (2 * W)'(c1_ff);
   end

   // stage 3: discriminant (a-d)^2 + 4bc, sign and magnitude
   always_comb begin
      disc     = $signed({3'b000, psq2_ff}) + (SW'(q2_ff) <<< 2);
      disc_neg = -disc;
      real3_in = !disc[SW-1];
      mag3_in  = real3_in ? DW'(disc) : DW'(disc_neg);
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         if (en[1]) begin
            v_ff[1] <= v_ff[0];
         end
         if (en[2]) begin
            v_ff[2] <= v_ff[1];
         end
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en[0]) begin
         tr1_ff <= tr1_in;
         pm1_ff <= pm1_in;
         b1_ff  <= in_b;
         c1_ff  <= in_c;
      end
      if (en[1]) begin
         tr2_ff  <= tr1_ff;
         psq2_ff <= psq2_in;
         q2_ff   <= q2_in;
      end
      if (en[2]) begin
         tr3_ff   <= tr2_ff;
         mag3_ff  <= mag3_in;
         real3_ff <= real3_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_trace = tr3_ff;
   assign out_mag   = mag3_ff;
   assign out_real  = real3_ff;

endmodule : eig_front

`default_nettype wire

### rtl/core/eig_root.sv
// ============================================================================
// eig_root : pipelined floored square root
// One root bit per stage, restoring digit recurrence on a bit pair of the
// operand; trace and real flag ride along with each beat.
// ============================================================================
`default_nettype none

module eig_root import eig_pkg::*; #(
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [ENTRY_WIDTH:0] in_trace,
   input  logic [2*ENTRY_WIDTH+1:0]    in_mag,
   input  logic                        in_real,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [ENTRY_WIDTH:0] out_trace,
   output logic [ENTRY_WIDTH:0]        out_root,
   output logic                        out_real
);

   localparam int W   = ENTRY_WIDTH;
   localparam int RW  = W + 1;
   localparam int DW  = 2 * RW;
   localparam int RMW = RW + 2;

   // per-stage outputs
   logic [RW-1:0]        v_q;
   logic [RW-1:0]        en;
   logic [RW-1:0]        root_q  [RW];
   logic signed [W:0]    tr_q    [RW];
   logic [RW-1:0]        real_q;
   logic [RMW-1:0]       rem_q   [RW-1];
   logic [DW-1:0]        x_q     [RW-1];

   // per-stage inputs
   logic                 v_src   [RW];
   logic [RW-1:0]        root_src[RW];
   logic signed [W:0]    tr_src  [RW];
   logic                 real_src[RW];
   logic [RMW-1:0]       rem_src [RW];
   logic [DW-1:0]        x_src   [RW];

   assign in_ready = en[0];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic              v_ff;
      logic [RW-1:0]     root_ff;
      logic signed [W:0] tr_ff;
      logic              real_ff;
      logic [RMW-1:0]    rem_cat;
      logic [RMW-1:0]    trial;
      logic              take;

      // feed from the input port or the previous stage
      if (k == 0) begin : g_first
         assign v_src[k]    = in_valid;
         assign root_src[k] = '0;
         assign tr_src[k]   = in_trace;
         assign real_src[k] = in_real;
         assign rem_src[k]  = '0;
         assign x_src[k]    = in_mag;
      end else begin : g_next
         assign v_src[k]    = v_q[k-1];
         assign root_src[k] = root_q[k-1];
         assign tr_src[k]   = tr_q[k-1];
         assign real_src[k] = real_q[k-1];
         assign rem_src[k]  = rem_q[k-1];
         assign x_src[k]    = x_q[k-1];
      end

      // advance when this stage or any later one holds a bubble
      assign en[k] = out_ready || !(&v_q[RW-1:k]);

      // bring down the next bit pair, try root*4+1
      assign rem_cat = {rem_src[k][RMW-3:0], x_src[k][DW-1:DW-2]};
      assign trial   = {root_src[k], 2'b01};
      assign take    = rem_cat >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en[k]) begin
            v_ff <= v_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            root_ff <= {root_src[k][RW-2:0], take};
            tr_ff   <= tr_src[k];
            real_ff <= real_src[k];
         end
      end

      // remainder and remaining operand bits are needed only downstream
      if (k < RW - 1) begin : g_carry
         logic [RMW-1:0] rem_ff;
         logic [DW-1:0]  x_ff;

         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff <= take ? rem_cat - trial : rem_cat;
               x_ff   <= {x_src[k][DW-3:0], 2'b00};
            end
         end

         assign rem_q[k] = rem_ff;
         assign x_q[k]   = x_ff;
      end

      assign v_q[k]    = v_ff;
      assign root_q[k] = root_ff;
      assign tr_q[k]   = tr_ff;
      assign real_q[k] = real_ff;
   end

   assign out_valid = v_q[RW-1];
   assign out_trace = tr_q[RW-1];
   assign out_root  = root_q[RW-1];
   assign out_real  = real_q[RW-1];

endmodule : eig_root

`default_nettype wire

### rtl/core/eig_out.sv
// ============================================================================
// eig_out : result stage
// Forms trace plus and minus root (or trace and root for a complex pair),
// saturates to the result width and holds the beat for the consumer.
// ============================================================================
`default_nettype none

module eig_out import eig_pkg::*; #(
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [ENTRY_WIDTH:0] in_trace,
   input  logic [ENTRY_WIDTH:0]        in_root,
   input  logic                        in_real,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [OUT_WIDTH-1:0] out_first,
   output logic signed [OUT_WIDTH-1:0] out_second,
   output logic                        out_real
);

   localparam int W  = ENTRY_WIDTH;
   localparam int XW = (W + 3 > OUT_WIDTH + 1) ? W + 3 : OUT_WIDTH + 1;
   localparam logic signed [XW-1:0] MAX_X = XW'(OUT_MAX);
   localparam logic signed [XW-1:0] MIN_X = XW'(OUT_MIN);

   logic                        v_ff;
   logic                        en;
   logic signed [OUT_WIDTH-1:0] first_ff;
   logic signed [OUT_WIDTH-1:0] second_ff;
   logic                        real_ff;

   logic signed [XW-1:0]        tr_x;
   logic signed [XW-1:0]        root_x;
   logic signed [XW-1:0]        first_x;
   logic signed [XW-1:0]        second_x;
   logic signed [OUT_WIDTH-1:0] first_in;
   logic signed [OUT_WIDTH-1:0] second_in;

   assign en       = out_ready || !v_ff;
   assign in_ready = en;

   // pick the pair and clamp each to the result range
   always_comb begin
      tr_x     = XW'(in_trace);
      root_x   = $signed(XW'(in_root));
      first_x  = in_real ? tr_x + root_x : tr_x;
      second_x = in_real ? tr_x - root_x : root_x;
      priority if (first_x > MAX_X) begin
         first_in = OUT_WIDTH'(MAX_X);
      end else if (first_x < MIN_X) begin
         first_in = OUT_WIDTH'(MIN_X);
      end else begin
         first_in = OUT_WIDTH'(first_x);
      end
      priority if (second_x > MAX_X) begin
         second_in = OUT_WIDTH'(MAX_X);
      end else if (second_x < MIN_X) begin
         second_in = OUT_WIDTH'(MIN_X);
      end else begin
         second_in = OUT_WIDTH'(second_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (en) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         real_ff   <= in_real;
      end
   end

   assign out_valid  = v_ff;
   assign out_first  = first_ff;
   assign out_second = second_ff;
   assign out_real   = real_ff;

endmodule : eig_out

`default_nettype wire

### rtl/core/eig_check.sv
// ============================================================================
// eig_check : port-level checks for eigenvalues_2x2
// Watches the result channel over time, input readiness and the ordering of the results.
// ============================================================================
`default_nettype none

module eig_check import eig_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [OUT_WIDTH-1:0] rsp_first_value,
   input logic signed [OUT_WIDTH-1:0] rsp_second_value,
   input logic                        rsp_is_real
);

   // a held result beat keeps its payload
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_value)
         && $stable(rsp_second_value) && $stable(rsp_is_real))
      else $error("result beat changed while stalled");

   // reset leaves the pipeline empty
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // an empty output stage never blocks the input
   a_no_block : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // real pair comes larger first
   a_real_order : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_real |-> rsp_first_value >= rsp_second_value)
      else $error("real eigenvalues out of order");

   // complex pair has a positive imaginary part
   a_imag_pos : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_real |-> !rsp_second_value[OUT_WIDTH-1]
         && rsp_second_value != '0)
      else $error("complex pair with non-positive imaginary part");

endmodule : eig_check

bind eigenvalues_2x2 eig_check u_check (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_first_value (rsp_first_value),
   .rsp_second_value(rsp_second_value),
   .rsp_is_real     (rsp_is_real)
);

`default_nettype wire

### dv/eigen_check.sv
// ============================================================================
// eigen_check : result checker for the 2x2 eigenvalue block
// Watches both channels, computes the expected eigenvalue pair for every
// accepted matrix beat, and compares each result beat in order against it.
// ============================================================================
module eigen_check import eig_pkg::*; #(
   parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_top_left,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_top_right,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_bottom_left,
   input  logic signed [ENTRY_WIDTH-1:0] req_entry_bottom_right,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [OUT_WIDTH-1:0]   rsp_first_value,
   input  logic signed [OUT_WIDTH-1:0]   rsp_second_value,
   input  logic                          rsp_is_real,
   output int                            mismatch_total,
   output int                            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] first_value;
      logic signed [OUT_WIDTH-1:0] second_value;
      logic                        is_real;
   } eig_pair_type;

   eig_pair_type eig_queue[$];
   int           errors = 0;
   int           rsp_beats = 0;

   // clamp to the result range
   function automatic logic signed [OUT_WIDTH-1:0] clamp_out(input longint v);
      if (v > longint'(OUT_MAX)) v = longint'(OUT_MAX);
      if (v < longint'(OUT_MIN)) v = longint'(OUT_MIN);
      return v[OUT_WIDTH-1:0];
   endfunction

   // trace, discriminant (a-d)^2 + 4bc, floored root, then pair or real/imag
   function automatic eig_pair_type eigen_of(input longint a, input longint b,
                                             input longint c, input longint d);
      eig_pair_type res;
      longint       trace;
      longint       diff;
      longint       disc;
      longint       mag;
      longint       root;
      longint       cand;
      int           k;
      trace = a + d;
      diff  = a - d;
      disc  = diff * diff + 4 * b * c;
      mag   = (disc < 0) ? -disc : disc;
      root  = 0;
      for (k = ENTRY_WIDTH + 4; k >= 0; k--) begin
         cand = root | (longint'(1) << k);
         if (cand * cand <= mag) root = cand;
      end
      if (disc >= 0) begin
         res.first_value  = clamp_out(trace + root);
         res.second_value = clamp_out(trace - root);
         res.is_real      = 1'b1;
      end else begin
         res.first_value  = clamp_out(trace);
         res.second_value = clamp_out(root);
         res.is_real      = 1'b0;
      end
      return res;
   endfunction

   // print one line and count
   task automatic report_mismatch(input string msg);
      $display("%0t: beat %0d: %s", $time, rsp_beats, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      eig_pair_type want;
      if (!reset) begin
         // predict every accepted matrix beat
         if (req_valid && req_ready)
            eig_queue.push_back(eigen_of(longint'(req_entry_top_left),
                                         longint'(req_entry_top_right),
                                         longint'(req_entry_bottom_left),
                                         longint'(req_entry_bottom_right)));
         // compare each result beat with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (eig_queue.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = eig_queue.pop_front();
               if (rsp_first_value !== want.first_value)
                  report_mismatch($sformatf("first_value got %0d expected %0d",
                                            rsp_first_value, want.first_value));
               if (rsp_second_value !== want.second_value)
                  report_mismatch($sformatf("second_value got %0d expected %0d",
                                            rsp_second_value, want.second_value));
               if (rsp_is_real !== want.is_real)
                  report_mismatch($sformatf("is_real got %0b expected %0b",
                                            rsp_is_real, want.is_real));
            end
            rsp_beats++;
         end
      end
      mismatch_total <= errors;
      outstanding    <= eig_queue.size();
   end

endmodule : eigen_check

### dv/eigenvalues_2x2_tb.sv
// ============================================================================
// eigenvalues_2x2_tb : top-level testbench for the 2x2 eigenvalue block
// Drives directed and random matrices with random sender gaps and receiver
// stalls, including two long receiver hold-offs, and reports the verdict.
// ============================================================================
module eigenvalues_2x2_tb import eig_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EW = ENTRY_WIDTH_DEF;
   localparam int N_RANDOM = 1600;
   localparam logic signed [EW-1:0] E_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0] E_MIN = {1'b1, {(EW-1){1'b0}}};

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [EW-1:0]        req_entry_top_left;
   logic signed [EW-1:0]        req_entry_top_right;
   logic signed [EW-1:0]        req_entry_bottom_left;
   logic signed [EW-1:0]        req_entry_bottom_right;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [OUT_WIDTH-1:0] rsp_first_value;
   logic signed [OUT_WIDTH-1:0] rsp_second_value;
   logic                        rsp_is_real;
   int                          mismatch_total;
   int                          outstanding;
   int                          sent_count = 0;

   eigenvalues_2x2 #(.ENTRY_WIDTH(EW)) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_entry_top_left     (req_entry_top_left),
      .req_entry_top_right    (req_entry_top_right),
      .req_entry_bottom_left  (req_entry_bottom_left),
      .req_entry_bottom_right (req_entry_bottom_right),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_first_value        (rsp_first_value),
      .rsp_second_value       (rsp_second_value),
      .rsp_is_real            (rsp_is_real)
   );

   eigen_check #(.ENTRY_WIDTH(EW)) u_eigen_check (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_entry_top_left     (req_entry_top_left),
      .req_entry_top_right    (req_entry_top_right),
      .req_entry_bottom_left  (req_entry_bottom_left),
      .req_entry_bottom_right (req_entry_bottom_right),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_first_value        (rsp_first_value),
      .rsp_second_value       (rsp_second_value),
      .rsp_is_real            (rsp_is_real),
      .mismatch_total         (mismatch_total),
      .outstanding            (outstanding)
   );

   // free-running clock, 10 ns period
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // offer one matrix beat after a random gap, hold it until accepted
   task automatic send_matrix(input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
                              input logic signed [EW-1:0] c, input logic signed [EW-1:0] d);
      int gap;
      // every fourth stretch of 128 beats runs back to back
      gap = ((sent_count / 128) % 4 == 3) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_entry_top_left     <= a;
      req_entry_top_right    <= b;
      req_entry_bottom_left  <= c;
      req_entry_bottom_right <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // pick an entry near the edges of the range
   function automatic logic signed [EW-1:0] edge_entry();
      logic signed [EW-1:0] v;
      case ($urandom_range(0, 5))
         0: v = E_MAX;
         1: v = E_MIN;
         2: v = '0;
         3: v = '1;
         4: v = EW'(1);
         default: v = EW'($urandom());
      endcase
      return v;
   endfunction

   // receiver: random stall per beat, two long hold-offs to back up the pipe
   initial begin
      int hold;
      int beats_taken;
      beats_taken = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (beats_taken == 300 || beats_taken == 1000) hold = 200;
         else if ((beats_taken / 150) % 4 == 2) hold = 0;
         else hold = $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         beats_taken++;
      end
   end

   // stimulus and verdict
   initial begin
      logic signed [EW-1:0] a, b, c, d;
      int kind;
      reset                  <= 1'b1;
      req_valid              <= 1'b0;
      req_entry_top_left     <= '0;
      req_entry_top_right    <= '0;
      req_entry_bottom_left  <= '0;
      req_entry_bottom_right <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero discriminant, complex pairs, near-cancelling terms
      send_matrix('0, '0, '0, '0);
      send_matrix(E_MAX, E_MAX, E_MAX, E_MAX);
      send_matrix(E_MIN, E_MIN, E_MIN, E_MIN);
      send_matrix(E_MAX, E_MIN, E_MIN, E_MIN);
      send_matrix(E_MAX, E_MIN, E_MIN, E_MAX);
      send_matrix(E_MAX, E_MAX, E_MIN, E_MIN);
      send_matrix(E_MAX, E_MIN, E_MAX, E_MIN);
      send_matrix(E_MIN, E_MAX, E_MIN, E_MAX);
      send_matrix(E_MAX, '0, '0, E_MIN);
      send_matrix(16'sh0100, '0, '0, 16'sh0100);
      send_matrix(16'sh0300, '0, 16'sh1234, 16'sh0300);
      send_matrix(-16'sh0200, 16'sh0100, 16'sh0100, -16'sh0200);
      send_matrix('0, EW'(1), '1, '0);
      send_matrix('0, E_MAX, E_MIN, '0);
      send_matrix('0, E_MIN, E_MAX, '0);
      send_matrix(16'sh0005, 16'sh0003, -16'sh0002, 16'sh0001);
      send_matrix(16'sh0004, 16'sh0001, -16'sh0001, '0);
      send_matrix(16'sh0004, 16'sh0001, -16'sh0002, '0);
      send_matrix(16'sh0002, 16'sh0003, 16'sh0005, 16'sh0007);
      send_matrix('1, '1, '1, '1);
      send_matrix(E_MAX, '1, EW'(1), E_MIN);

      // random: mostly full range, some small values and special shapes
      for (int i = 0; i < N_RANDOM; i++) begin
         kind = $urandom_range(0, 9);
         a = EW'($urandom());
         b = EW'($urandom());
         c = EW'($urandom());
         d = EW'($urandom());
         if (kind == 6 || kind == 7) begin
            a = EW'($urandom_range(0, 128) - 64);
            b = EW'($urandom_range(0, 128) - 64);
            c = EW'($urandom_range(0, 128) - 64);
            d = EW'($urandom_range(0, 128) - 64);
         end else if (kind == 8) begin
            // zero discriminant: equal diagonal with one off-diagonal zero
            d = a;
            if ($urandom_range(0, 1)) b = '0;
            else c = '0;
         end else if (kind == 9) begin
            a = edge_entry();
            b = edge_entry();
            c = edge_entry();
            d = edge_entry();
         end
         send_matrix(a, b, c, d);
      end
      req_valid <= 1'b0;

      // drain, then allow for the pipeline depth
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_total == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule : eigenvalues_2x2_tb

### files.f
rtl/core/eig_pkg.sv
rtl/core/eig_front.sv
rtl/core/eig_root.sv
rtl/core/eig_out.sv
rtl/core/eigenvalues_2x2.sv
rtl/core/eig_check.sv
dv/eigen_check.sv
dv/eigenvalues_2x2_tb.sv
